// ===== design/assert_macros.svh =====
// Assertion macros shared by the cursor tracker RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset cycles included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/mct_pkg.sv =====
// Shared types, codes and helpers for the mouse cursor tracker.
// No dependencies; used by every module of the block.
package mct_pkg;

  // Event codes
  localparam logic [1:0] ACT_PREPARE = 2'd0;
  localparam logic [1:0] ACT_MOVE    = 2'd1;
  localparam logic [1:0] ACT_SET     = 2'd2;
  localparam logic [1:0] ACT_GOTO    = 2'd3;

  // Cursor modes (code three behaves as system mode)
  localparam logic [1:0] MODE_ABS = 2'd0;
  localparam logic [1:0] MODE_REL = 2'd1;
  localparam logic [1:0] MODE_SYS = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_ACCEL_MODE     = 3'd0;
  localparam logic [2:0] REG_THRESHOLD_LOW  = 3'd1;
  localparam logic [2:0] REG_THRESHOLD_HIGH = 3'd2;
  localparam logic [2:0] REG_CURSOR_MODE    = 3'd3;
  localparam logic [2:0] REG_WATCHED_MOUSE  = 3'd4;
  localparam logic [2:0] REG_MAX_X          = 3'd5;
  localparam logic [2:0] REG_MAX_Y          = 3'd6;
  localparam logic [2:0] REG_SCALE_RECIP    = 3'd7;

  // Reset values
  localparam logic [15:0] MAX_X_RST = 16'd1023;
  localparam logic [15:0] MAX_Y_RST = 16'd767;
  localparam logic [15:0] ONE_Q14   = 16'd16384;

  // Widths: accelerated delta (x4 of 16 bits) and scaled value
  localparam int ACC_W = 18;
  localparam int SCL_W = 21;
  localparam int FRAC_W = 14;

  typedef struct packed {
    logic [1:0]  accel_mode;
    logic [15:0] threshold_low;
    logic [15:0] threshold_high;
    logic [1:0]  cursor_mode;
    logic [7:0]  watched_mouse;
    logic [15:0] max_x;
    logic [15:0] max_y;
    logic [15:0] scale_recip;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         mouse_id;
    logic [1:0]         axis;
    logic signed [15:0] delta;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } in_item_t;

  // Clamp a signed value to 0..hi
  function automatic logic [31:0] clamp_pos(logic signed [32:0] v, logic [15:0] hi);
    logic [31:0] r;
    if (v[32]) begin
      r = '0;
    end else if (v > $signed({17'd0, hi})) begin
      r = {16'd0, hi};
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Saturate a 33-bit signed sum to 32 bits
  function automatic logic [31:0] sat32(logic signed [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== design/mct_cfg_regs.sv =====
// Configuration register file of the mouse cursor tracker.
// Depends on mct_pkg for register indexes, reset values and cfg_t.
module mct_cfg_regs
  import mct_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [15:0] wr_data,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  // Load one register per write word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_mode     <= 2'd0;
      cfg_r.threshold_low  <= 16'd0;
      cfg_r.threshold_high <= 16'd0;
      cfg_r.cursor_mode    <= MODE_ABS;
      cfg_r.watched_mouse  <= 8'd0;
      cfg_r.max_x          <= MAX_X_RST;
      cfg_r.max_y          <= MAX_Y_RST;
      cfg_r.scale_recip    <= ONE_Q14;
    end else if (wr_en) begin
      case (wr_index)
        REG_ACCEL_MODE:     cfg_r.accel_mode     <= wr_data[1:0];
        REG_THRESHOLD_LOW:  cfg_r.threshold_low  <= wr_data;
        REG_THRESHOLD_HIGH: cfg_r.threshold_high <= wr_data;
        REG_CURSOR_MODE:    cfg_r.cursor_mode    <= wr_data[1:0];
        REG_WATCHED_MOUSE:  cfg_r.watched_mouse  <= wr_data[7:0];
        REG_MAX_X:          cfg_r.max_x          <= wr_data;
        REG_MAX_Y:          cfg_r.max_y          <= wr_data;
        REG_SCALE_RECIP:    cfg_r.scale_recip    <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/mct_scale.sv =====
// Q2.14 scaler: multiplies by the reciprocal scale and truncates toward zero.
// Depends on mct_pkg for the value widths.
module mct_scale
  import mct_pkg::*;
(
  input  logic signed [ACC_W-1:0] value,
  input  logic [15:0]             recip,
  output logic signed [SCL_W-1:0] scaled
);

  logic [ACC_W-1:0]         mag;
  logic [ACC_W+15:0]        prod;
  logic [ACC_W+15-FRAC_W:0] quot;

  // Work on the magnitude so the shift truncates toward zero
  assign mag  = value[ACC_W-1] ? ACC_W'(-value) : ACC_W'(value);
  assign prod = mag * recip;
  assign quot = prod[ACC_W+15:FRAC_W];

  // Restore the sign
  assign scaled = value[ACC_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

endmodule

// ===== design/mct_update.sv =====
// Next-position logic of the mouse cursor tracker for one event.
// Depends on mct_pkg and instantiates two mct_scale units (x and y).
module mct_update
  import mct_pkg::*;
(
  input  cfg_t        cfg,
  input  in_item_t    item,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  output logic [31:0] pos_x_nxt,
  output logic [31:0] pos_y_nxt,
  output logic        bad_nxt
);

  logic                    mode_abs;
  logic                    mode_rel;
  logic                    mode_sys;
  logic [16:0]             delta_mag;
  logic signed [ACC_W-1:0] delta_ext;
  logic                    quad;
  logic                    dbl;
  logic signed [ACC_W-1:0] accel;
  logic signed [ACC_W-1:0] sx_in;
  logic signed [ACC_W-1:0] sy_in;
  logic signed [SCL_W-1:0] sx_out;
  logic signed [SCL_W-1:0] sy_out;
  logic signed [32:0]      abs_sum_x;
  logic signed [32:0]      abs_sum_y;
  logic signed [32:0]      rel_sum_x;
  logic signed [32:0]      rel_sum_y;
  logic                    move_hit;

  // Decode the cursor mode; code three acts as system mode
  assign mode_abs = (cfg.cursor_mode == MODE_ABS);
  assign mode_rel = (cfg.cursor_mode == MODE_REL);
  assign mode_sys = cfg.cursor_mode[1];

  // Accelerate the delta by threshold compare and shift
  assign delta_ext = ACC_W'(item.delta);
  assign delta_mag = item.delta[15] ? 17'(-delta_ext) : 17'(delta_ext);
  assign quad  = cfg.accel_mode[1] && (delta_mag > {1'b0, cfg.threshold_high});
  assign dbl   = (cfg.accel_mode != 2'd0) && (delta_mag > {1'b0, cfg.threshold_low});
  assign accel = quad ? (delta_ext <<< 2) : (dbl ? (delta_ext <<< 1) : delta_ext);

  // Share the scalers between move deltas and set positions
  assign sx_in = (item.action == ACT_MOVE) ? accel : ACC_W'(item.pos_x);
  assign sy_in = (item.action == ACT_MOVE) ? accel : ACC_W'(item.pos_y);

  mct_scale u_scale_x (
    .value  (sx_in),
    .recip  (cfg.scale_recip),
    .scaled (sx_out)
  );

  mct_scale u_scale_y (
    .value  (sy_in),
    .recip  (cfg.scale_recip),
    .scaled (sy_out)
  );

  // Form the sums one bit wider so they cannot overflow
  assign abs_sum_x = $signed({pos_x[31], pos_x}) + 33'(sx_out);
  assign abs_sum_y = $signed({pos_y[31], pos_y}) + 33'(sy_out);
  assign rel_sum_x = $signed({pos_x[31], pos_x}) + 33'(accel);
  assign rel_sum_y = $signed({pos_y[31], pos_y}) + 33'(accel);

  assign move_hit = (item.action == ACT_MOVE) && (item.mouse_id == cfg.watched_mouse) &&
                    !item.axis[1];

  // Pick the new position; hold it for events the mode does not take
  always_comb begin
    pos_x_nxt = pos_x;
    pos_y_nxt = pos_y;
    bad_nxt   = 1'b0;
    if (item.action == ACT_GOTO) begin
      if (mode_rel) begin
        bad_nxt = 1'b1;
      end else begin
        pos_x_nxt = clamp_pos(33'(item.pos_x), cfg.max_x);
        pos_y_nxt = clamp_pos(33'(item.pos_y), cfg.max_y);
      end
    end else if (mode_sys) begin
      if (item.action == ACT_SET) begin
        pos_x_nxt = clamp_pos(33'(sx_out), cfg.max_x);
        pos_y_nxt = clamp_pos(33'(sy_out), cfg.max_y);
      end
    end else if (item.action == ACT_PREPARE) begin
      if (mode_rel) begin
        pos_x_nxt = '0;
        pos_y_nxt = '0;
      end
    end else if (move_hit) begin
      if (mode_abs) begin
        if (!item.axis[0]) begin
          pos_x_nxt = clamp_pos(abs_sum_x, cfg.max_x);
        end else begin
          pos_y_nxt = clamp_pos(abs_sum_y, cfg.max_y);
        end
      end else begin
        if (!item.axis[0]) begin
          pos_x_nxt = sat32(rel_sum_x);
        end else begin
          pos_y_nxt = sat32(rel_sum_y);
        end
      end
    end
  end

endmodule

// ===== design/mouse_cursor_tracker.sv =====
// Mouse cursor tracker: keeps a cursor position from prepare, move, set and
// goto events and returns one word per event with both positions and an error
// flag. Throughput is one event per clock while the output is not stalled; a
// result word passes the input register, then the position/result register,
// and holds there until taken. The rate is set by the position update loop,
// which holds the accelerate, Q2.14 scale multiply, add and clamp.
// Configuration writes are always ready and must only be issued while no
// event is in flight.
// Depends on mct_pkg, mct_cfg_regs, mct_update and assert_macros.svh.
`include "assert_macros.svh"

module mouse_cursor_tracker
  import mct_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // event input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [7:0]         in_mouse_id,
  input  logic [1:0]         in_axis,
  input  logic signed [15:0] in_delta,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_cursor_x,
  output logic signed [31:0] out_cursor_y,
  output logic               out_bad_request,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  cfg_t        cfg;
  in_item_t    item_r;
  logic        s1_valid_r;
  logic        out_valid_r;
  logic [31:0] pos_x_r;
  logic [31:0] pos_y_r;
  logic        bad_r;
  logic [31:0] pos_x_nxt;
  logic [31:0] pos_y_nxt;
  logic        bad_nxt;
  logic        out_free;
  logic        advance;
  logic        in_take;

  // Configuration registers
  assign cfg_ready = 1'b1;

  mct_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Handshake: the result register frees when empty or taken this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Capture the input word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.action   <= in_action;
      item_r.mouse_id <= in_mouse_id;
      item_r.axis     <= in_axis;
      item_r.delta    <= in_delta;
      item_r.pos_x    <= in_pos_x;
      item_r.pos_y    <= in_pos_y;
    end
  end

  // Event update logic
  mct_update u_update (
    .cfg       (cfg),
    .item      (item_r),
    .pos_x     (pos_x_r),
    .pos_y     (pos_y_r),
    .pos_x_nxt (pos_x_nxt),
    .pos_y_nxt (pos_y_nxt),
    .bad_nxt   (bad_nxt)
  );

  // Advance the position state and the result word together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
    end else if (out_free) begin
      out_valid_r <= advance;
      if (advance) begin
        pos_x_r <= pos_x_nxt;
        pos_y_r <= pos_y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      bad_r <= bad_nxt;
    end
  end

  // The position registers double as the result payload
  assign out_valid       = out_valid_r;
  assign out_cursor_x    = pos_x_r;
  assign out_cursor_y    = pos_y_r;
  assign out_bad_request = bad_r;

  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r && !s1_valid_r, "pipeline not empty after reset")
  `ASSERT_CLK(a_stall_needs_item, in_stall |-> s1_valid_r && out_valid_r, "stall without held word")
  `ASSERT_CLK(a_advance_fills, advance |=> out_valid_r, "advanced word lost")
  `ASSERT_CLK(a_bad_only_goto, advance && item_r.action != ACT_GOTO |=> !out_bad_request, "error flag on non-goto event")

endmodule
